// File: rtl/core/btb_one_and_two_bit_predictor_defines.svh
// ----------------------------------------------------------------------------
// BTB predictor assertion macros
// Concurrent assertion wrappers shared by the predictor RTL; empty when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BTB_ONE_AND_TWO_BIT_PREDICTOR_DEFINES_SVH
`define BTB_ONE_AND_TWO_BIT_PREDICTOR_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define BTBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define BTBP_ASSERT_NORST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BTBP_ASSERT(label, prop, msg)
`define BTBP_ASSERT_NORST(label, prop, msg)
`endif

`endif

// File: rtl/core/btbp_pkg.sv
// ----------------------------------------------------------------------------
// BTB predictor package
// Shared widths, counter codes, mode encoding and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package btbp_pkg;

    localparam int ADDR_W = 32;
    localparam int CTR_W  = 2;

    localparam logic [CTR_W-1:0] CTR_STRONG_NT = 2'd0;
    localparam logic [CTR_W-1:0] CTR_STRONG_T  = 2'd3;

    typedef enum logic {
        MODE_CLEAR,
        MODE_RUN
    } btbp_mode_t;

    typedef struct packed {
        logic              present;
        logic              taken;
        logic [ADDR_W-1:0] target;
        logic              ok1;
        logic              ok2;
    } btbp_result_t;

endpackage

`default_nettype wire

// File: rtl/core/btbp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module btbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/btbp_update.sv
// ----------------------------------------------------------------------------
// BTB predictor update
// Resolves the transaction, scores the stored entry and builds the new entry.
// ----------------------------------------------------------------------------
`default_nettype none

module btbp_update
    import btbp_pkg::*;
#(
    parameter int IDX_W = 8
) (
    input  wire logic                    [ADDR_W-1:0]       branch_pc,
    input  wire logic signed             [ADDR_W-1:0]       branch_offset,
    input  wire logic                                       is_return,
    input  wire logic                    [ADDR_W-1:0]       next_pc,
    input  wire logic                                       rd_valid,
    input  wire logic                    [ADDR_W-IDX_W-1:0] rd_tag,
    input  wire logic                    [ADDR_W-1:0]       rd_target,
    input  wire logic                                       rd_lob,
    input  wire logic                    [CTR_W-1:0]        rd_ctr,
    output logic                         [ADDR_W-IDX_W-1:0] wr_tag,
    output logic                         [ADDR_W-1:0]       wr_target,
    output logic                                            wr_lob,
    output logic                         [CTR_W-1:0]        wr_ctr,
    output btbp_result_t                                    result
);

    logic [ADDR_W-1:0]       sum;
    logic [ADDR_W-1:0]       target;
    logic [ADDR_W-IDX_W-1:0] tag;
    logic                    taken;
    logic                    present;
    logic [CTR_W-1:0]        ctr_upd;

    always_comb
    begin
        sum     = branch_pc + $unsigned(branch_offset);
        target  = is_return ? '0 : sum;
        taken   = is_return || (next_pc == sum);
        tag     = branch_pc[ADDR_W-1:IDX_W];
        present = rd_valid && (rd_tag == tag);

        // saturating bimodal counter
        ctr_upd = rd_ctr;
        if (taken && (rd_ctr != CTR_STRONG_T))
        begin
            ctr_upd = rd_ctr + 1'b1;
        end
        else if (!taken && (rd_ctr != CTR_STRONG_NT))
        begin
            ctr_upd = rd_ctr - 1'b1;
        end

        if (present)
        begin
            wr_tag    = rd_tag;
            wr_target = rd_target;
            wr_lob    = taken;
            wr_ctr    = ctr_upd;
        end
        else
        begin
            wr_tag    = tag;
            wr_target = target;
            wr_lob    = 1'b1;
            wr_ctr    = is_return ? CTR_STRONG_T : CTR_STRONG_NT;
        end

        result.present = present;
        result.taken   = taken;
        result.target  = target;
        result.ok1     = present && (rd_lob == taken);
        result.ok2     = present && (rd_ctr[CTR_W-1] == taken);
    end

endmodule

`default_nettype wire

// File: rtl/core/btb_one_and_two_bit_predictor.sv
// ----------------------------------------------------------------------------
// BTB with one-bit and two-bit predictors
// Direct-mapped branch target buffer scored and trained per resolved branch.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle unless the output stalls; each result is
// registered in the branch stage when accepted and passes to the output
// register as that stage advances, which waits on a stalled valid output. The
// table sits in one RAM with one read and one write port: the read is issued
// when a transaction is accepted, the entry is rewritten as it moves to the
// output register, and a one-entry write-back register forwards the latest
// write to a following read of the same index. After reset the block clears
// the valid bits in all entries, stalling input meanwhile. TABLE_ENTRIES must
// be a power of two; index = low bits of branch_pc, tag = remaining high bits.
`default_nettype none

`include "btb_one_and_two_bit_predictor_defines.svh"

module btb_one_and_two_bit_predictor
    import btbp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic        [ADDR_W-1:0] branch_pc,
    input  wire logic signed [ADDR_W-1:0] branch_offset,
    input  wire logic                     is_return,
    input  wire logic        [ADDR_W-1:0] next_pc,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          entry_present,
    output logic                          resolved_taken,
    output logic             [ADDR_W-1:0] computed_target,
    output logic                          one_bit_correct,
    output logic                          two_bit_correct
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int TAG_W  = ADDR_W - IDX_W;
    // word layout: {valid, tag, target, last outcome, counter}
    localparam int WORD_W = 1 + TAG_W + ADDR_W + 1 + CTR_W;

    btbp_mode_t mode_reg, mode_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clearing;

    logic                     b_valid_reg, b_valid_next;
    logic        [ADDR_W-1:0] b_pc_reg;
    logic signed [ADDR_W-1:0] b_off_reg;
    logic                     b_ret_reg;
    logic        [ADDR_W-1:0] b_next_reg;

    logic              fwd_valid_reg;
    logic [IDX_W-1:0]  fwd_idx_reg;
    logic [WORD_W-1:0] fwd_word_reg;

    logic         out_valid_reg, out_valid_next;
    btbp_result_t out_res_reg;

    logic              in_acc;
    logic              b_move;
    logic [IDX_W-1:0]  b_idx;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] entry_word;
    logic [WORD_W-1:0] new_word;

    logic              wr_lob;
    logic [TAG_W-1:0]  wr_tag;
    logic [ADDR_W-1:0] wr_target;
    logic [CTR_W-1:0]  wr_ctr;
    btbp_result_t      res;
    logic              scored_miss;

    // ---------------- clearing sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        clr_cnt_next = clr_cnt_reg;
        clearing     = 1'b0;
        case (mode_reg)
            MODE_CLEAR:
            begin
                clearing     = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {IDX_W{1'b1}})
                begin
                    mode_next = MODE_RUN;
                end
            end
            MODE_RUN:
            begin
                mode_next = MODE_RUN;
            end
            default:
            begin
                mode_next = MODE_CLEAR;
            end
        endcase
    end

    // ---------------- handshake ----------------
    always_comb
    begin
        b_move         = b_valid_reg && (!out_valid_reg || !out_stall);
        in_stall       = clearing || (b_valid_reg && !b_move);
        in_acc         = in_valid && !in_stall;
        b_valid_next   = in_acc || (b_valid_reg && !b_move);
        out_valid_next = b_move || (out_valid_reg && out_stall);
        b_idx          = b_pc_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            b_pc_reg   <= branch_pc;
            b_off_reg  <= branch_offset;
            b_ret_reg  <= is_return;
            b_next_reg <= next_pc;
        end
        if (b_move)
        begin
            out_res_reg <= res;
        end
        if (ram_we)
        begin
            fwd_idx_reg  <= ram_waddr;
            fwd_word_reg <= ram_wdata;
        end
    end

    // ---------------- table ----------------
    always_comb
    begin
        ram_we    = clearing || b_move;
        ram_waddr = clearing ? clr_cnt_reg : b_idx;
        new_word  = {1'b1, wr_tag, wr_target, wr_lob, wr_ctr};
        ram_wdata = clearing ? '0 : new_word;
        // the read of a back-to-back transaction misses the write of the one before
        entry_word = (fwd_valid_reg && (fwd_idx_reg == b_idx)) ? fwd_word_reg : ram_rdata;
    end

    btbp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_acc),
        .raddr (branch_pc[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    btbp_update #(
        .IDX_W (IDX_W)
    ) u_update (
        .branch_pc     (b_pc_reg),
        .branch_offset (b_off_reg),
        .is_return     (b_ret_reg),
        .next_pc       (b_next_reg),
        .rd_valid      (entry_word[WORD_W-1]),
        .rd_tag        (entry_word[WORD_W-2 -: TAG_W]),
        .rd_target     (entry_word[CTR_W+1 +: ADDR_W]),
        .rd_lob        (entry_word[CTR_W]),
        .rd_ctr        (entry_word[CTR_W-1:0]),
        .wr_tag        (wr_tag),
        .wr_target     (wr_target),
        .wr_lob        (wr_lob),
        .wr_ctr        (wr_ctr),
        .result        (res)
    );

    // ---------------- outputs ----------------
    assign out_valid       = out_valid_reg;
    assign entry_present   = out_res_reg.present;
    assign resolved_taken  = out_res_reg.taken;
    assign computed_target = out_res_reg.target;
    assign one_bit_correct = out_res_reg.ok1;
    assign two_bit_correct = out_res_reg.ok2;
    assign scored_miss     = !out_res_reg.present && (out_res_reg.ok1 || out_res_reg.ok2);

    // ---------------- assertions ----------------
    `BTBP_ASSERT_NORST(a_clear_blocks_input, clearing |-> in_stall, "input taken during clear")
    `BTBP_ASSERT(a_run_write_has_item, (ram_we && !clearing) |-> b_valid_reg, "stray table write")
    `BTBP_ASSERT(a_accept_fills_stage, in_acc |=> b_valid_reg, "accepted transaction lost")
    `BTBP_ASSERT(a_miss_not_scored, out_valid_reg |-> !scored_miss, "miss was scored")

endmodule

`default_nettype wire

// File: tb/btb_one_and_two_bit_predictor_tb.sv
// ----------------------------------------------------------------------------
// BTB one-bit / two-bit predictor testbench
// Drives resolved branch and return transactions through the buffer, predicts
// hit, outcome, target and both predictor scores with a local table model,
// and checks every result in order under varied idle and stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module btb_one_and_two_bit_predictor_tb;
    import btbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int TAG_W         = ADDR_W - IDX_W;
    localparam int N_DIRECTED    = 24;
    localparam int N_PHASES      = 4;
    localparam int ITEMS_PER_PH  = 225;
    localparam int POOL_SIZE     = 24;
    localparam int HOLD_CYCLES   = 64;
    localparam int DRAIN_CYCLES  = 8;

    typedef struct packed {
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] off;
        logic              ret;
        logic [ADDR_W-1:0] nxt;
        logic              typed;
        btbp_result_t      want;
    } branch_row_t;

    logic                     clk             = 1'b0;
    logic                     rst_n           = 1'b0;
    logic                     in_valid        = 1'b0;
    logic                     in_stall;
    logic        [ADDR_W-1:0] branch_pc       = '0;
    logic signed [ADDR_W-1:0] branch_offset   = '0;
    logic                     is_return       = 1'b0;
    logic        [ADDR_W-1:0] next_pc         = '0;
    logic                     out_valid;
    logic                     out_stall       = 1'b0;
    logic                     entry_present;
    logic                     resolved_taken;
    logic        [ADDR_W-1:0] computed_target;
    logic                     one_bit_correct;
    logic                     two_bit_correct;

    // local copy of the buffer state
    logic             btb_valid [TABLE_ENTRIES];
    logic [TAG_W-1:0] btb_tag   [TABLE_ENTRIES];
    logic             btb_last  [TABLE_ENTRIES];
    logic [CTR_W-1:0] btb_ctr   [TABLE_ENTRIES];

    btbp_result_t expected_outcomes [$];

    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_reqs    = 0;
    int hold_served  = 0;
    int hold_left    = 0;
    int mismatches   = 0;
    int n_sent       = 0;
    int n_checked    = 0;
    int n_hits       = 0;
    int n_returns    = 0;
    int n_taken      = 0;
    bit failed       = 1'b0;

    logic [ADDR_W-1:0] pool_pc  [POOL_SIZE];
    logic [ADDR_W-1:0] pool_off [POOL_SIZE];
    logic              pool_ret [POOL_SIZE];

    branch_row_t directed_rows [N_DIRECTED] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b1,
          '{1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0}},
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0004, 1'b0, '0},
        // target wraps to zero
        '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0000_0000, 1'b1,
          '{1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0}},
        '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFE, 1'b0, '0},
        '{32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b1,
          '{1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0}},
        // return: allocate strongly taken, then hit with both predictors right
        '{32'h0000_1000, 32'h0000_1234, 1'b1, 32'hDEAD_BEEF, 1'b1,
          '{1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0}},
        '{32'h0000_1000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1,
          '{1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b1}},
        // same index, other tag: replaces, then the old branch misses again
        '{32'h0000_2000, 32'h0000_0010, 1'b0, 32'h0000_0000, 1'b0, '0},
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, '0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0000_0000, 1'b0, '0},
        // counter walk: up to saturation, down to saturation, alternate
        '{32'h0000_0345, 32'h0000_0010, 1'b0, 32'h0000_0355, 1'b0, '0},
        '{32'h0000_0345, 32'h0000_0010, 1'b0, 32'h0000_0355, 1'b0, '0},
        '{32'h0000_0345, 32'h0000_0010, 1'b0, 32'h0000_0355, 1'b0, '0},
        '{32'h0000_0345, 32'h0000_0010, 1'b0, 32'h0000_0355, 1'b0, '0},
        '{32'h0000_0345, 32'h0000_0010, 1'b0, 32'h0000_0355, 1'b0, '0},
        '{32'h0000_0345, 32'h0000_0010, 1'b0, 32'h0000_0349, 1'b0, '0},
        '{32'h0000_0345, 32'h0000_0010, 1'b0, 32'h0000_0349, 1'b0, '0},
        '{32'h0000_0345, 32'h0000_0010, 1'b0, 32'h0000_0349, 1'b0, '0},
        '{32'h0000_0345, 32'h0000_0010, 1'b0, 32'h0000_0349, 1'b0, '0},
        '{32'h0000_0345, 32'h0000_0010, 1'b0, 32'h0000_0355, 1'b0, '0},
        '{32'h0000_0345, 32'h0000_0010, 1'b0, 32'h0000_0349, 1'b0, '0},
        '{32'h0000_0345, 32'h0000_0010, 1'b1, 32'h0000_0000, 1'b0, '0}
    };

    btb_one_and_two_bit_predictor #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .branch_pc       (branch_pc),
        .branch_offset   (branch_offset),
        .is_return       (is_return),
        .next_pc         (next_pc),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .entry_present   (entry_present),
        .resolved_taken  (resolved_taken),
        .computed_target (computed_target),
        .one_bit_correct (one_bit_correct),
        .two_bit_correct (two_bit_correct)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // scores the entry against the outcome, then trains or allocates it
    function automatic btbp_result_t predict_branch_outcome(
        logic [ADDR_W-1:0] pc, logic [ADDR_W-1:0] off, logic ret, logic [ADDR_W-1:0] nxt);
        btbp_result_t     r;
        logic [IDX_W-1:0] idx;
        logic [TAG_W-1:0] tg;
        logic [CTR_W-1:0] c;
        r = '0;
        if (ret)
        begin
            r.taken = 1'b1;
        end
        else
        begin
            r.target = pc + off;
            r.taken  = (nxt == r.target);
        end
        idx = pc[IDX_W-1:0];
        tg  = pc[ADDR_W-1:IDX_W];
        r.present = btb_valid[idx] && (btb_tag[idx] == tg);
        if (r.present)
        begin
            c     = btb_ctr[idx];
            r.ok1 = (btb_last[idx] == r.taken);
            r.ok2 = (c[CTR_W-1] == r.taken);
            btb_last[idx] = r.taken;
            if (r.taken && c != CTR_STRONG_T)
                c = c + 1'b1;
            else if (!r.taken && c != CTR_STRONG_NT)
                c = c - 1'b1;
            btb_ctr[idx] = c;
        end
        else
        begin
            btb_valid[idx] = 1'b1;
            btb_tag[idx]   = tg;
            btb_last[idx]  = 1'b1;
            btb_ctr[idx]   = ret ? CTR_STRONG_T : CTR_STRONG_NT;
        end
        return r;
    endfunction

    // offers one transaction and returns in the step it is accepted
    task automatic send_branch(logic [ADDR_W-1:0] pc, logic [ADDR_W-1:0] off, logic ret,
                               logic [ADDR_W-1:0] nxt, logic typed, btbp_result_t want);
        btbp_result_t pred;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        branch_pc     <= pc;
        branch_offset <= off;
        is_return     <= ret;
        next_pc       <= nxt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = predict_branch_outcome(pc, off, ret, nxt);
        expected_outcomes = {expected_outcomes, (typed ? want : pred)};
        n_sent++;
        if (pred.present)
            n_hits++;
        if (ret)
            n_returns++;
        if (pred.taken)
            n_taken++;
    endtask

    // sender goes quiet until every outstanding result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_outcomes.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (hold_reqs != hold_served)
        begin
            hold_served = hold_reqs;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        btbp_result_t got;
        btbp_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {entry_present, resolved_taken, computed_target,
                   one_bit_correct, two_bit_correct};
            if (expected_outcomes.size() == 0)
            begin
                failed = 1'b1;
                $display("unexpected result transaction: present=%0b taken=%0b target=%h",
                         got.present, got.taken, got.target);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                n_checked++;
                if (got !== want)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch #%0d: exp present=%0b taken=%0b target=%h %s%0b %s%0b",
                                 n_checked, want.present, want.taken, want.target,
                                 "ok1=", want.ok1, "ok2=", want.ok2);
                        $display("    got present=%0b taken=%0b target=%h ok1=%0b ok2=%0b",
                                 got.present, got.taken, got.target, got.ok1, got.ok2);
                    end
                end
            end
        end
    end

    initial
    begin
        int                ph;
        int                n;
        int                k;
        int                sel;
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] tgt;
        logic [ADDR_W-1:0] nxt;
        logic              ret;

        for (k = 0; k < TABLE_ENTRIES; k++)
        begin
            btb_valid[k] = 1'b0;
            btb_tag[k]   = '0;
            btb_last[k]  = 1'b0;
            btb_ctr[k]   = '0;
        end
        // later pool entries share an index with earlier ones to force conflicts
        for (k = 0; k < POOL_SIZE; k++)
        begin
            pool_pc[k] = $urandom;
            if (k >= 16)
                pool_pc[k][IDX_W-1:0] = pool_pc[k-8][IDX_W-1:0];
            pool_off[k] = ($urandom_range(1) == 0) ? $urandom
                        : ADDR_W'(signed'($urandom_range(8191)) - 4096);
            pool_ret[k] = ($urandom_range(99) < 20);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < N_DIRECTED; k++)
            send_branch(directed_rows[k].pc, directed_rows[k].off, directed_rows[k].ret,
                        directed_rows[k].nxt, directed_rows[k].typed, directed_rows[k].want);
        wait_drained();

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            for (n = 0; n < ITEMS_PER_PH; n++)
            begin
                // long output hold-off while the sender keeps pushing
                if (ph == 0 && n == 100)
                    hold_reqs++;
                if ($urandom_range(99) < 80)
                begin
                    sel = $urandom_range(POOL_SIZE - 1);
                    pc  = pool_pc[sel];
                    off = ($urandom_range(99) < 70) ? pool_off[sel] : $urandom;
                    ret = ($urandom_range(99) < 5) ? !pool_ret[sel] : pool_ret[sel];
                end
                else
                begin
                    pc  = $urandom;
                    off = $urandom;
                    ret = ($urandom_range(99) < 15);
                end
                tgt = pc + off;
                sel = $urandom_range(99);
                if (ret || sel >= 80)
                    nxt = $urandom;
                else if (sel < 50)
                    nxt = tgt;
                else
                    nxt = tgt + 32'd4;
                send_branch(pc, off, ret, nxt, 1'b0, '0);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_outcomes.size() != 0)
            failed = 1'b1;

        $display("%0d transactions sent, %0d results checked, %0d mismatches",
                 n_sent, n_checked, mismatches);
        $display("coverage: %0d buffer hits, %0d returns, %0d taken, four idle/stall mixes",
                 n_hits, n_returns, n_taken);
        if (!failed)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl/core
rtl/core/btbp_pkg.sv
rtl/core/btbp_ram.sv
rtl/core/btbp_update.sv
rtl/core/btb_one_and_two_bit_predictor.sv
tb/btb_one_and_two_bit_predictor_tb.sv
